/* hdl/fjoc_pkg.sv */
package fjoc_pkg;

    typedef enum logic [3:0] {
        PH_LEAD       = 4'd0,
        PH_OPEN       = 4'd1,
        PH_KEY        = 4'd2,
        PH_AFTER_KEY  = 4'd3,
        PH_BEFORE_VAL = 4'd4,
        PH_STR_VAL    = 4'd5,
        PH_NUM_VAL    = 4'd6,
        PH_LITERAL    = 4'd7,
        PH_AFTER_VAL  = 4'd8,
        PH_NEED_KEY   = 4'd9,
        PH_TRAIL      = 4'd10,
        PH_ERROR      = 4'd11
    } phase_t;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] lit_kind;
        logic [2:0] lit_pos;
    } fjoc_state_t;

    localparam fjoc_state_t STATE_RESET = '{phase: PH_LEAD, lit_kind: 2'd0, lit_pos: 3'd0};

    // Character of a literal keyword at a given position.
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (kind)
            LIT_TRUE: begin
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            LIT_NULL: begin
                case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        case (kind)
            LIT_FALSE: len = 3'd5;
            default:   len = 3'd4;
        endcase
        return len;
    endfunction

endpackage

/* hdl/fjoc_next_state.sv */
module fjoc_next_state
    import fjoc_pkg::*;
(
    input  fjoc_state_t cur,
    input  logic [7:0]  char_byte,
    output fjoc_state_t nxt
);

    logic       is_space;
    logic       is_num;
    logic [2:0] pos_inc;
    phase_t     after_val;

    assign is_space = (char_byte == CH_SPACE);
    assign is_num   = ((char_byte >= CH_ZERO) && (char_byte <= CH_NINE))
                      || (char_byte == CH_DOT) || (char_byte == CH_MINUS);
    assign pos_inc  = cur.lit_pos + 3'd1;

    always_comb begin
        if (is_space) begin
            after_val = PH_AFTER_VAL;
        end else if (char_byte == CH_COMMA) begin
            after_val = PH_NEED_KEY;
        end else if (char_byte == CH_RBRACE) begin
            after_val = PH_TRAIL;
        end else begin
            after_val = PH_ERROR;
        end
    end

    always_comb begin
        nxt = cur;
        unique case (cur.phase)
            PH_LEAD: begin
                if (is_space) nxt.phase = PH_LEAD;
                else if (char_byte == CH_LBRACE) nxt.phase = PH_OPEN;
                else nxt.phase = PH_ERROR;
            end
            PH_OPEN: begin
                if (is_space) nxt.phase = PH_OPEN;
                else if (char_byte == CH_QUOTE) nxt.phase = PH_KEY;
                else if (char_byte == CH_RBRACE) nxt.phase = PH_TRAIL;
                else nxt.phase = PH_ERROR;
            end
            PH_KEY: begin
                nxt.phase = (char_byte == CH_QUOTE) ? PH_AFTER_KEY : PH_KEY;
            end
            PH_AFTER_KEY: begin
                if (is_space) nxt.phase = PH_AFTER_KEY;
                else if (char_byte == CH_COLON) nxt.phase = PH_BEFORE_VAL;
                else nxt.phase = PH_ERROR;
            end
            PH_BEFORE_VAL: begin
                if (is_space) begin
                    nxt.phase = PH_BEFORE_VAL;
                end else if (char_byte == CH_QUOTE) begin
                    nxt.phase = PH_STR_VAL;
                end else if (is_num) begin
                    nxt.phase = PH_NUM_VAL;
                end else if (char_byte == lit_char(LIT_TRUE, 3'd0)) begin
                    nxt = '{phase: PH_LITERAL, lit_kind: LIT_TRUE, lit_pos: 3'd1};
                end else if (char_byte == lit_char(LIT_FALSE, 3'd0)) begin
                    nxt = '{phase: PH_LITERAL, lit_kind: LIT_FALSE, lit_pos: 3'd1};
                end else if (char_byte == lit_char(LIT_NULL, 3'd0)) begin
                    nxt = '{phase: PH_LITERAL, lit_kind: LIT_NULL, lit_pos: 3'd1};
                end else begin
                    nxt.phase = PH_ERROR;
                end
            end
            PH_STR_VAL: begin
                nxt.phase = (char_byte == CH_QUOTE) ? PH_AFTER_VAL : PH_STR_VAL;
            end
            PH_NUM_VAL: begin
                nxt.phase = is_num ? PH_NUM_VAL : after_val;
            end
            PH_LITERAL: begin
                if ((cur.lit_kind > LIT_NULL) || (cur.lit_pos >= lit_len(cur.lit_kind))
                    || (char_byte != lit_char(cur.lit_kind, cur.lit_pos))) begin
                    nxt.phase = PH_ERROR;
                end else begin
                    nxt.lit_pos = pos_inc;
                    nxt.phase = (pos_inc == lit_len(cur.lit_kind)) ? PH_AFTER_VAL : PH_LITERAL;
                end
            end
            PH_AFTER_VAL: begin
                nxt.phase = after_val;
            end
            PH_NEED_KEY: begin
                if (is_space) nxt.phase = PH_NEED_KEY;
                else if (char_byte == CH_QUOTE) nxt.phase = PH_KEY;
                else nxt.phase = PH_ERROR;
            end
            PH_TRAIL: begin
                nxt.phase = is_space ? PH_TRAIL : PH_ERROR;
            end
            default: begin
                nxt.phase = PH_ERROR;
            end
        endcase
    end

endmodule

/* hdl/flat_json_object_checker.sv */
// The verdict is registered: a final byte is held in the input register, then its verdict goes to the output register.
// Throughput: one byte per cycle, set by the phase update loop, but for the stall below.
// A verdict waiting in the output register stalls only a following final byte.
// Reset (aresetn low, synchronous) empties the input and output registers and
// returns the parser to waiting for the opening brace.
module flat_json_object_checker
    import fjoc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] accepted, [7:1] zero
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    fjoc_state_t state_reg;
    fjoc_state_t state_next;
    logic        out_valid_reg;
    logic        out_acc_reg;
    logic        out_free;
    logic        advance;
    logic        verdict;

    fjoc_next_state u_next (
        .cur       (state_reg),
        .char_byte (in_char_reg),
        .nxt       (state_next)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        verdict = (state_next.phase == PH_TRAIL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= in_last_reg ? STATE_RESET : state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            out_acc_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_acc_reg};

    // A message end always brings the parser back to the start.
    a_final_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (state_reg.phase == PH_LEAD))
        else $error("parser not reset after final byte");

    // A verdict appears only for a final byte that went through.
    a_verdict_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance && in_last_reg))
        else $error("verdict without a final byte");

    // Literal matching only ever runs with a known keyword.
    a_literal_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_LITERAL) |-> (state_reg.lit_kind <= LIT_NULL))
        else $error("literal phase with unknown keyword");

endmodule
